@@ rtl/toie_pkg.sv @@
`default_nettype none
package toie_pkg;
  localparam int NUM_REGS = 19;
  localparam logic [4:0] REG_FLAGS = 5'd17;
  localparam logic [4:0] REG_REM = 5'd18;

  localparam logic [4:0] OP_MOV = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_PUSHF = 5'd3,
    OP_POPF = 5'd4, OP_CALL = 5'd5, OP_RET = 5'd6, OP_INC = 5'd7, OP_DEC = 5'd8,
    OP_ADD = 5'd9, OP_SUB = 5'd10, OP_MUL = 5'd11, OP_DIV = 5'd12, OP_MOD = 5'd13,
    OP_REM = 5'd14, OP_NOT = 5'd15, OP_XOR = 5'd16, OP_OR = 5'd17, OP_AND = 5'd18,
    OP_SHL = 5'd19, OP_SHR = 5'd20, OP_CMP = 5'd21, OP_JMP = 5'd22, OP_JE = 5'd23,
    OP_JNE = 5'd24, OP_JG = 5'd25, OP_JGE = 5'd26, OP_JL = 5'd27, OP_JLE = 5'd28,
    OP_PRN = 5'd29;

  localparam logic [1:0] KIND_REG = 2'd0, KIND_MEM = 2'd1;

  localparam logic [2:0] ERR_OK = 3'd0, ERR_EMPTY = 3'd1, ERR_FULL = 3'd2,
    ERR_DIV0 = 3'd3, ERR_UNWR = 3'd4, ERR_ADDR = 3'd5;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture the input item
    logic fetch;      // register memory read data
    logic div_start;  // begin division
    logic commit;     // write back and form the result
  } toie_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_div;   // item reaches the divider
    logic div_done;
  } toie_sts_t;
endpackage
`default_nettype wire

@@ rtl/toie_div.sv @@
`default_nettype none
module toie_div
  import toie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] x,
  input  wire logic [31:0] y,
  output logic             done,
  output logic [31:0]      q,
  output logic [31:0]      r
);
  logic [31:0] uy, quo, rem;
  logic [5:0]  cnt;
  logic        busy, nq, nr;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, uy};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        uy   <= y[31] ? -y : y;
        quo  <= x[31] ? -x : x;
        rem  <= 32'd0;
        nq   <= x[31] ^ y[31];
        nr   <= x[31];
      end else if (busy) begin
        // restoring step: one quotient bit per cycle
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitude of 0x80000000 / -1 keeps the wrap, matching the overflow case
  assign q = nq ? -quo : quo;
  assign r = nr ? -rem : rem;
endmodule
`default_nettype wire

@@ rtl/toie_ctrl.sv @@
`default_nettype none
module toie_ctrl
  import toie_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire toie_sts_t sts,
  output toie_cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_DIV   = 5'b00100,
    S_EXEC  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;
  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        if (in_fire) state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.commit = 1'b1;
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

@@ rtl/toie_dp.sv @@
`default_nettype none
module toie_dp
  import toie_pkg::*;
#(
  parameter int MEM_WORDS = 1024,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire toie_cmd_t   cmd,
  output toie_sts_t        sts,
  output logic             mem_clearing,
  input  wire logic [4:0]  req_type,
  input  wire logic [1:0]  a_kind,
  input  wire logic [31:0] a_value,
  input  wire logic [1:0]  b_kind,
  input  wire logic [31:0] b_value,
  input  wire logic [15:0] next_line,
  output logic [31:0]      continue_line,
  output logic             block_end,
  output logic             print_valid,
  output logic [31:0]      print_value,
  output logic [2:0]       error_code
);
  localparam int MAW = $clog2(MEM_WORDS);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  logic [31:0] regs [NUM_REGS];
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] stk [STACK_DEPTH];
  logic [SCW-1:0] scount;
  logic [MAW:0] clr_addr;

  logic [4:0]  op;
  logic [1:0]  ak, bk;
  logic [31:0] av, bv;
  logic [15:0] nl;
  logic [31:0] mem_a, mem_b, stk_top;
  logic [31:0] quo, rem;
  logic        div_done;

  // capture and fetch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req_type; ak <= a_kind; av <= a_value;
      bk <= b_kind; bv <= b_value; nl <= next_line;
    end
    if (cmd.fetch) begin
      mem_a <= mem[av[MAW-1:0]];
      mem_b <= mem[bv[MAW-1:0]];
      stk_top <= stk[SAW'(scount - SCW'(1))];
    end
  end

  // operand resolution
  logic a_reg_ok, a_mem_ok, b_reg_ok, b_mem_ok;
  logic [31:0] ra, rb, va, vb;
  logic [2:0]  ea_place, ea_val, eb_val;
  assign a_reg_ok = av < 32'(NUM_REGS);
  assign b_reg_ok = bv < 32'(NUM_REGS);
  assign a_mem_ok = av < 32'(MEM_WORDS);
  assign b_mem_ok = bv < 32'(MEM_WORDS);
  assign ra = a_reg_ok ? regs[av[4:0]] : 32'd0;
  assign rb = b_reg_ok ? regs[bv[4:0]] : 32'd0;

  always_comb begin
    ea_place = ERR_UNWR; ea_val = ERR_OK; eb_val = ERR_OK; va = av; vb = bv;
    if (ak == KIND_REG) begin
      ea_place = a_reg_ok ? ERR_OK : ERR_ADDR; ea_val = ea_place; va = ra;
    end else if (ak == KIND_MEM) begin
      ea_place = a_mem_ok ? ERR_OK : ERR_ADDR; ea_val = ea_place; va = mem_a;
    end
    if (bk == KIND_REG) begin
      eb_val = b_reg_ok ? ERR_OK : ERR_ADDR; vb = rb;
    end else if (bk == KIND_MEM) begin
      eb_val = b_mem_ok ? ERR_OK : ERR_ADDR; vb = mem_b;
    end
  end

  // execute
  logic signed [31:0] f;
  logic        take, wr_a, wr_rem, wr_flags, push, pop;
  logic [31:0] res, push_val, cont;
  logic [2:0]  err;
  logic        be, pv;
  logic [63:0] prod;
  assign f = regs[REG_FLAGS];
  assign prod = va * vb;

  function automatic logic [2:0] first(input logic [2:0] e1, input logic [2:0] e2);
    first = (e1 != ERR_OK) ? e1 : e2;
  endfunction

  always_comb begin
    err = ERR_OK; res = 32'd0; wr_a = 1'b0; wr_rem = 1'b0; wr_flags = 1'b0;
    push = 1'b0; pop = 1'b0; push_val = vb; cont = {16'd0, nl};
    be = 1'b0; pv = 1'b0; take = 1'b0;
    case (op)
      OP_MOV: begin err = first(ea_place, eb_val); res = vb; wr_a = 1'b1; end
      OP_PUSH, OP_PUSHF: begin
        push_val = (op == OP_PUSH) ? va : regs[REG_FLAGS];
        err = (op == OP_PUSH) ? ea_val : ERR_OK;
        if (err == ERR_OK && scount >= SCW'(STACK_DEPTH)) err = ERR_FULL;
        push = 1'b1;
      end
      OP_POP, OP_POPF: begin
        err = ea_place;
        if (err == ERR_OK && scount == '0) err = ERR_EMPTY;
        res = stk_top; wr_a = 1'b1; pop = 1'b1;
      end
      OP_CALL: begin
        be = 1'b1; err = ea_val;
        if (err == ERR_OK && scount >= SCW'(STACK_DEPTH)) err = ERR_FULL;
        push_val = {16'd0, nl}; push = 1'b1; cont = va;
      end
      OP_RET: begin
        be = 1'b1;
        if (scount == '0) err = ERR_EMPTY;
        pop = 1'b1; cont = stk_top;
      end
      OP_INC, OP_DEC, OP_REM, OP_NOT: begin
        err = ea_place; wr_a = 1'b1;
        case (op)
          OP_INC: res = va + 32'd1;
          OP_DEC: res = va - 32'd1;
          OP_REM: res = regs[REG_REM];
          default: res = ~va;
        endcase
      end
      OP_ADD, OP_SUB, OP_MUL, OP_XOR, OP_OR, OP_AND, OP_SHL, OP_SHR: begin
        err = first(ea_place, eb_val); wr_a = 1'b1;
        case (op)
          OP_ADD: res = va + vb;
          OP_SUB: res = va - vb;
          OP_MUL: res = prod[31:0];
          OP_XOR: res = va ^ vb;
          OP_OR:  res = va | vb;
          OP_AND: res = va & vb;
          OP_SHL: res = va << vb[4:0];
          default: res = 32'($signed(va) >>> vb[4:0]);
        endcase
      end
      OP_DIV: begin
        err = first(ea_place, eb_val);
        if (err == ERR_OK && vb == 32'd0) err = ERR_DIV0;
        res = quo; wr_a = 1'b1; wr_rem = 1'b1;
      end
      OP_MOD: begin
        err = first(ea_val, eb_val);
        if (err == ERR_OK && vb == 32'd0) err = ERR_DIV0;
        wr_rem = 1'b1;
      end
      OP_CMP: begin err = first(ea_val, eb_val); res = va - vb; wr_flags = 1'b1; end
      OP_JMP, OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE: begin
        be = 1'b1;
        case (op)
          OP_JMP: take = 1'b1;
          OP_JE:  take = f == 0;
          OP_JNE: take = f != 0;
          OP_JG:  take = f > 0;
          OP_JGE: take = f >= 0;
          OP_JL:  take = f < 0;
          default: take = f <= 0;
        endcase
        if (take) begin err = ea_val; cont = va; end
      end
      OP_PRN: begin pv = 1'b1; err = ea_val; end
      default: ;
    endcase
    if (err != ERR_OK) cont = {16'd0, nl};
  end

  assign sts.need_div = (op == OP_DIV || op == OP_MOD) && err == ERR_OK;
  assign sts.div_done = div_done;

  toie_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .x(va), .y(vb),
    .done(div_done), .q(quo), .r(rem)
  );

  logic ok;
  assign ok = cmd.commit && err == ERR_OK;
  assign mem_clearing = !clr_addr[MAW];

  // register file; the remainder wins when div names it as destination
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= 32'd0;
    end else if (ok) begin
      if (wr_flags) regs[REG_FLAGS] <= res;
      if (wr_a && ak == KIND_REG && !(wr_rem && av[4:0] == REG_REM)) regs[av[4:0]] <= res;
      if (wr_rem) regs[REG_REM] <= rem;
    end
  end

  // data memory, swept to zero after reset
  always_ff @(posedge clk) begin
    if (mem_clearing) mem[clr_addr[MAW-1:0]] <= 32'd0;
    else if (ok && wr_a && ak == KIND_MEM) mem[av[MAW-1:0]] <= res;
  end
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (mem_clearing) clr_addr <= clr_addr + 1'b1;
  end

  // stack
  always_ff @(posedge clk) begin
    if (ok && push) stk[scount[SAW-1:0]] <= push_val;
  end
  always_ff @(posedge clk) begin
    if (rst) scount <= '0;
    else if (ok && push) scount <= scount + 1'b1;
    else if (ok && pop) scount <= scount - 1'b1;
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      continue_line <= cont;
      block_end <= be;
      print_valid <= pv;
      print_value <= (pv && err == ERR_OK) ? va : 32'd0;
      error_code <= err;
    end
  end
endmodule
`default_nettype wire

@@ rtl/two_operand_instruction_executor.sv @@
`default_nettype none
// Executes one pre-decoded instruction per transfer on a 19-register machine with a
// MEM_WORDS word memory and a STACK_DEPTH stack, returning one result transfer each.
// The input is captured, memory and stack are read into registers, then the item
// executes into the result register, which is then offered; the next input is taken
// the cycle after the result transfer, so one item is finished before the next is taken;
// div and mod that do not fault pass through the bit-serial divider first. After reset
// the data memory is swept to zero, one word a cycle over all MEM_WORDS words, and no
// input is taken until that pass ends.
module two_operand_instruction_executor
  import toie_pkg::*;
#(
  parameter int MEM_WORDS = 1024,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // req_type[4:0], a_kind[6:5], a_value[38:7], b_kind[40:39], b_value[72:41],
  // next_line[88:73], zero fill
  input  wire logic [95:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // continue_line[31:0], block_end[32], print_valid[33], print_value[65:34],
  // error_code[68:66], zero fill
  output logic [71:0]       m_tdata
);
  toie_cmd_t cmd;
  toie_sts_t sts;
  logic ctrl_ready, clearing, fire;
  logic [31:0] cl, pvv;
  logic be, pv;
  logic [2:0] ec;

  assign s_tready = ctrl_ready && !clearing;
  assign fire = s_tvalid && s_tready;

  toie_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(fire), .in_ready(ctrl_ready),
    .out_valid(m_tvalid), .out_ready(m_tready), .sts(sts), .cmd(cmd)
  );

  toie_dp #(.MEM_WORDS(MEM_WORDS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .mem_clearing(clearing),
    .req_type(s_tdata[4:0]), .a_kind(s_tdata[6:5]), .a_value(s_tdata[38:7]),
    .b_kind(s_tdata[40:39]), .b_value(s_tdata[72:41]), .next_line(s_tdata[88:73]),
    .continue_line(cl), .block_end(be), .print_valid(pv), .print_value(pvv),
    .error_code(ec)
  );

  assign m_tdata = {3'd0, ec, pvv, pv, be, cl};

  // hold the result while it waits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  // no input taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while result pending");
  a_clr: assert property (@(posedge clk) disable iff (rst) clearing |-> !s_tready)
    else $error("input taken during memory clear");
endmodule
`default_nettype wire

@@ dv/two_operand_instruction_executor_tb.sv @@
`timescale 1ns / 1ps
module two_operand_instruction_executor_tb;
  import toie_pkg::*;

  localparam int MEM_WORDS   = 1024;
  localparam int STACK_DEPTH = 256;
  localparam logic [4:0] OP_NOP = 5'd30;
  localparam logic [1:0] KIND_IMM = 2'd2;

  // packed from the highest field down, so req_type lands in the lowest bits
  typedef struct packed {
    logic [15:0] next_line;
    logic [31:0] b_value;
    logic [1:0]  b_kind;
    logic [31:0] a_value;
    logic [1:0]  a_kind;
    logic [4:0]  req_type;
  } instr_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [31:0] print_value;
    logic        print_valid;
    logic        block_end;
    logic [31:0] continue_line;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  two_operand_instruction_executor #(.MEM_WORDS(MEM_WORDS), .STACK_DEPTH(STACK_DEPTH))
    u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  always #1 clk = ~clk;

  // Shadow machine state
  logic [31:0] regs [NUM_REGS];
  logic [31:0] mem [MEM_WORDS];
  logic [31:0] stk [STACK_DEPTH];
  int unsigned depth;

  instr_t   pending_instrs[$];
  outcome_t expected_outcomes[$];
  int       fail_count = 0;
  bit       stim_done = 1'b0;

  // Validate an operand; record the first fault only
  function automatic void locate(input logic [1:0] k, input logic [31:0] v,
                                 input bit dest, inout logic [2:0] err);
    if (k == KIND_REG) begin
      if (v >= NUM_REGS && err == ERR_OK) err = ERR_ADDR;
    end else if (k == KIND_MEM) begin
      if (v >= MEM_WORDS && err == ERR_OK) err = ERR_ADDR;
    end else if (dest && err == ERR_OK) err = ERR_UNWR;
  endfunction

  function automatic logic [31:0] rd(input logic [1:0] k, input logic [31:0] v);
    if (k == KIND_REG) return (v < NUM_REGS) ? regs[v] : 32'd0;
    if (k == KIND_MEM) return (v < MEM_WORDS) ? mem[v] : 32'd0;
    return v;
  endfunction

  function automatic void wr(input logic [1:0] k, input logic [31:0] v,
                             input logic [31:0] d);
    if (k == KIND_REG) regs[v] = d;
    else mem[v] = d;
  endfunction

  function automatic void signed_divide(input logic [31:0] x, input logic [31:0] y,
                                        output logic [31:0] q, output logic [31:0] r);
    if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) begin
      q = x; r = '0;
    end else begin
      q = $signed(x) / $signed(y);
      r = $signed(x) % $signed(y);
    end
  endfunction

  // Execute one instruction on the shadow machine and return its outcome
  function automatic outcome_t execute(input instr_t it);
    outcome_t o;
    logic [2:0] err;
    logic [31:0] x, y, q, r;
    logic signed [31:0] f;
    bit take;
    err = ERR_OK;
    o = '0;
    o.continue_line = {16'd0, it.next_line};
    f = regs[REG_FLAGS];
    case (it.req_type)
      OP_MOV: begin
        locate(it.a_kind, it.a_value, 1, err);
        locate(it.b_kind, it.b_value, 0, err);
        if (err == ERR_OK) wr(it.a_kind, it.a_value, rd(it.b_kind, it.b_value));
      end
      OP_PUSH, OP_PUSHF: begin
        if (it.req_type == OP_PUSH) locate(it.a_kind, it.a_value, 0, err);
        y = (it.req_type == OP_PUSH) ? rd(it.a_kind, it.a_value) : regs[REG_FLAGS];
        if (err == ERR_OK) begin
          if (depth >= STACK_DEPTH) err = ERR_FULL;
          else begin stk[depth] = y; depth++; end
        end
      end
      OP_POP, OP_POPF: begin
        locate(it.a_kind, it.a_value, 1, err);
        if (err == ERR_OK) begin
          if (depth == 0) err = ERR_EMPTY;
          else begin depth--; wr(it.a_kind, it.a_value, stk[depth]); end
        end
      end
      OP_CALL: begin
        o.block_end = 1'b1;
        locate(it.a_kind, it.a_value, 0, err);
        if (err == ERR_OK) begin
          if (depth >= STACK_DEPTH) err = ERR_FULL;
          else begin
            stk[depth] = {16'd0, it.next_line}; depth++;
            o.continue_line = rd(it.a_kind, it.a_value);
          end
        end
      end
      OP_RET: begin
        o.block_end = 1'b1;
        if (depth == 0) err = ERR_EMPTY;
        else begin depth--; o.continue_line = stk[depth]; end
      end
      OP_INC, OP_DEC, OP_REM, OP_NOT: begin
        locate(it.a_kind, it.a_value, 1, err);
        if (err == ERR_OK) begin
          x = rd(it.a_kind, it.a_value);
          case (it.req_type)
            OP_INC:  x = x + 1;
            OP_DEC:  x = x - 1;
            OP_REM:  x = regs[REG_REM];
            default: x = ~x;
          endcase
          wr(it.a_kind, it.a_value, x);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_XOR, OP_OR, OP_AND, OP_SHL, OP_SHR: begin
        locate(it.a_kind, it.a_value, 1, err);
        locate(it.b_kind, it.b_value, 0, err);
        if (err == ERR_OK) begin
          x = rd(it.a_kind, it.a_value);
          y = rd(it.b_kind, it.b_value);
          case (it.req_type)
            OP_ADD:  x = x + y;
            OP_SUB:  x = x - y;
            OP_MUL:  x = x * y;
            OP_XOR:  x = x ^ y;
            OP_OR:   x = x | y;
            OP_AND:  x = x & y;
            OP_SHL:  x = x << y[4:0];
            default: x = $signed(x) >>> y[4:0];
          endcase
          wr(it.a_kind, it.a_value, x);
        end
      end
      OP_DIV, OP_MOD: begin
        locate(it.a_kind, it.a_value, it.req_type == OP_DIV, err);
        locate(it.b_kind, it.b_value, 0, err);
        if (err == ERR_OK) begin
          x = rd(it.a_kind, it.a_value);
          y = rd(it.b_kind, it.b_value);
          if (y == 0) err = ERR_DIV0;
          else begin
            signed_divide(x, y, q, r);
            if (it.req_type == OP_DIV) wr(it.a_kind, it.a_value, q);
            regs[REG_REM] = r;
          end
        end
      end
      OP_CMP: begin
        locate(it.a_kind, it.a_value, 0, err);
        locate(it.b_kind, it.b_value, 0, err);
        if (err == ERR_OK)
          regs[REG_FLAGS] = rd(it.a_kind, it.a_value) - rd(it.b_kind, it.b_value);
      end
      OP_JMP, OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE: begin
        o.block_end = 1'b1;
        case (it.req_type)
          OP_JMP:  take = 1;
          OP_JE:   take = (f == 0);
          OP_JNE:  take = (f != 0);
          OP_JG:   take = (f > 0);
          OP_JGE:  take = (f >= 0);
          OP_JL:   take = (f < 0);
          default: take = (f <= 0);
        endcase
        // an untaken jump never reads its operand, so it cannot fault
        if (take) begin
          locate(it.a_kind, it.a_value, 0, err);
          if (err == ERR_OK) o.continue_line = rd(it.a_kind, it.a_value);
        end
      end
      OP_PRN: begin
        o.print_valid = 1'b1;
        locate(it.a_kind, it.a_value, 0, err);
        if (err == ERR_OK) o.print_value = rd(it.a_kind, it.a_value);
      end
      default: ;
    endcase
    if (err != ERR_OK) o.continue_line = {16'd0, it.next_line};
    o.error_code = err;
    return o;
  endfunction

  // Random operand: mostly legal registers and low addresses, sometimes wild
  function automatic void pick_operand(output logic [1:0] k, output logic [31:0] v);
    k = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       v = $urandom;
      1:       v = (k == KIND_REG) ? $urandom_range(19, 31) :
                   $urandom_range(MEM_WORDS, MEM_WORDS+3);
      default: v = (k == KIND_REG) ? $urandom_range(0, 18) :
                   (k == KIND_MEM) ? $urandom_range(0, 15) :
                   ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7) - 3);
    endcase
  endfunction

  function automatic instr_t mk(input logic [4:0] op, input logic [1:0] ak,
                                input logic [31:0] av, input logic [1:0] bk,
                                input logic [31:0] bv);
    instr_t it;
    it.req_type = op; it.a_kind = ak; it.a_value = av;
    it.b_kind = bk; it.b_value = bv; it.next_line = 16'($urandom);
    return it;
  endfunction

  initial begin
    instr_t it;
    for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) mem[i] = '0;
    depth = 0;
    // Directed: extremes, errors, overflowing divide, stack empty
    pending_instrs.push_back(mk(OP_RET, KIND_REG, 0, KIND_REG, 0));
    pending_instrs.push_back(mk(OP_POP, KIND_REG, 1, KIND_REG, 0));
    pending_instrs.push_back(mk(OP_MOV, KIND_REG, 0, KIND_IMM, 32'h8000_0000));
    pending_instrs.push_back(mk(OP_DIV, KIND_REG, 0, KIND_IMM, 32'hFFFF_FFFF));
    pending_instrs.push_back(mk(OP_DIV, KIND_REG, 0, KIND_IMM, 0));
    pending_instrs.push_back(mk(OP_MOD, KIND_IMM, 32'h7FFF_FFFF, KIND_IMM, -7));
    pending_instrs.push_back(mk(OP_REM, KIND_MEM, MEM_WORDS - 1, KIND_REG, 0));
    pending_instrs.push_back(mk(OP_MOV, KIND_IMM, 5, KIND_REG, 1));
    pending_instrs.push_back(mk(OP_MOV, KIND_REG, 19, KIND_MEM, MEM_WORDS));
    pending_instrs.push_back(mk(OP_ADD, KIND_MEM, 32'hFFFF_FFFF, KIND_IMM, 1));
    pending_instrs.push_back(mk(OP_SHR, KIND_REG, 0, 2'd3, 33));
    pending_instrs.push_back(mk(OP_SHL, KIND_REG, 0, KIND_IMM, 32'hFFFF_FFFF));
    pending_instrs.push_back(mk(OP_CMP, KIND_IMM, 0, KIND_IMM, 1));
    pending_instrs.push_back(mk(OP_JE, KIND_REG, 99, KIND_REG, 0));
    pending_instrs.push_back(mk(OP_JL, KIND_IMM, 32'hFFFF_FFFF, KIND_REG, 0));
    pending_instrs.push_back(mk(OP_CALL, KIND_IMM, 12, KIND_REG, 0));
    pending_instrs.push_back(mk(OP_RET, KIND_REG, 0, KIND_REG, 0));
    pending_instrs.push_back(mk(OP_PRN, KIND_REG, REG_REM, KIND_REG, 0));
    pending_instrs.push_back(mk(OP_NOP, KIND_REG, 0, KIND_REG, 0));
    pending_instrs.push_back(mk(5'd31, 2'd3, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF));
    for (int i = 0; i < 22; i++)
      pending_instrs.push_back(mk(i[4:0], KIND_REG, 2, KIND_MEM, 3));
    // Fill the stack to the top and beyond, then drain it past empty
    for (int i = 0; i < STACK_DEPTH + 2; i++)
      pending_instrs.push_back(mk(OP_PUSH, KIND_IMM, $urandom, KIND_REG, 0));
    pending_instrs.push_back(mk(OP_CALL, KIND_IMM, 1, KIND_REG, 0));
    for (int i = 0; i < STACK_DEPTH + 2; i++)
      pending_instrs.push_back(mk(($urandom_range(0, 2) == 0) ? OP_RET : OP_POPF,
                                  KIND_REG, $urandom_range(0, 18), KIND_REG, 0));
    // Random program
    for (int i = 0; i < 540; i++) begin
      it.req_type = 5'($urandom_range(0, 31));
      pick_operand(it.a_kind, it.a_value);
      pick_operand(it.b_kind, it.b_value);
      it.next_line = 16'($urandom);
      pending_instrs.push_back(it);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: bursts with random gaps
  int gap_left = 0, burst_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_outcomes.push_back(execute(pending_instrs.pop_front()));
      end
      if ((s_tvalid && !s_tready)) begin
        // hold the item until it is taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_instrs.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, pending_instrs[0]};
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        end else burst_left <= burst_left - 1;
      end else begin
        s_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off
  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > 1200 && cyc < 1500) m_tready <= 1'b0;
    else if (cyc[9:8] == 2'b11) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[68:0];
      if (expected_outcomes.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        fail_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (got.continue_line != want.continue_line) begin
          $error("continue_line exp %h got %h", want.continue_line, got.continue_line);
          fail_count++;
        end
        if (got.block_end != want.block_end) begin
          $error("block_end exp %b got %b", want.block_end, got.block_end);
          fail_count++;
        end
        if (got.print_valid != want.print_valid) begin
          $error("print_valid exp %b got %b", want.print_valid, got.print_valid);
          fail_count++;
        end
        if (got.print_value != want.print_value) begin
          $error("print_value exp %h got %h", want.print_value, got.print_value);
          fail_count++;
        end
        if (got.error_code != want.error_code) begin
          $error("error_code exp %0d got %0d", want.error_code, got.error_code);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (stim_done && !s_tvalid && expected_outcomes.size() == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
